// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent is always met by a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/lzss_pkg.sv -----
// Types and constants shared by the LZSS window decompressor modules.
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SIZE);
  localparam logic [WIN_AW-1:0] WRITE_START = WIN_AW'(12'hfee);

  localparam int MATCH_MIN = 3;
  localparam int MAX_MATCH = 15 + MATCH_MIN;
  localparam int CNT_W     = $clog2(MAX_MATCH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LIT,
    CMD_MATCH
  } cmd_kind_t;

  // One unit of work for the copy engine.
  typedef struct packed {
    logic              clear;  // restart the window before this command
    cmd_kind_t         kind;
    logic [WIN_AW-1:0] data;   // literal byte in the low bits, or match offset
    logic [CNT_W-1:0]  count;  // bytes to emit for a match
    logic              done;   // the final byte of this command ends the stream
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/lzss_window_decompressor.sv -----
// Top level of the LZSS decompressor with a 4096-byte history window.
`default_nettype none
`include "assert_macros.svh"

// LZSS decompressor, 4 KiB window. Compressed bytes come in on the input
// channel, one per transfer; decompressed bytes leave on the output channel,
// one per transfer, with run_last marking the final byte caused by an input
// byte and stream_done marking the byte that reaches output_length. Write
// output_length on the configuration port before a stream starts, and set
// stream_start on its first byte: the window reads as zero, the write pointer
// returns to 0xfee and the flag state restarts. The window is not swept on a
// restart; a fill count marks which entries the stream has written, so there
// is no clearing pass and no dead time after reset or stream_start. Timing: a
// parser stage takes one input byte per cycle while its four-entry command
// queue has room; flag bytes and match low bytes produce no output byte. The
// copy engine behind the queue emits one byte per cycle while the output is
// not stalled: a literal is popped and then emitted, and a match (3 to 18
// bytes, or fewer at the end of a stream) is first loaded from the queue and
// then copied byte by byte. The engine's single window read port and its
// one-byte-per-cycle copy loop set the sustained rate on match-heavy data.
// Input after the stream is complete is taken and dropped.
module lzss_window_decompressor (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lzss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output lzss_pkg::out_item_t out_data,
  input  wire                 cfg_wr_en,
  input  wire [31:0]          cfg_wr_data
);
  import lzss_pkg::*;

  logic [31:0] output_length;
  logic        in_accept;
  logic        q_push, q_pop, q_valid, q_full;
  cmd_t        push_cmd, pop_cmd;

  // Hold the stream length; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= 32'd0;
    end else if (cfg_wr_en) begin
      output_length <= cfg_wr_data;
    end
  end

  // Take a byte whenever the queue can hold the command it may raise.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  lzss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .in_data       (in_data),
    .output_length (output_length),
    .push          (q_push),
    .cmd           (push_cmd)
  );

  lzss_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (pop_cmd),
    .valid (q_valid),
    .full  (q_full)
  );

  lzss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The parser never pushes into a full queue, and the engine never pops an empty one.
  `ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full), "command pushed into full queue")
  `ASSERT_ALWAYS(a_no_underflow, !(q_pop && !q_valid), "command popped from empty queue")
  // A match command always asks for between one and the longest match of bytes.
  `ASSERT_IMPLIES(a_match_count, q_push && (push_cmd.kind == CMD_MATCH), (push_cmd.count != '0) && (push_cmd.count <= CNT_W'(MAX_MATCH)), "match command with bad byte count")

endmodule

`default_nettype wire

// ----- sv/lzss_front.sv -----
// Token parser: takes compressed bytes and issues literal and match commands.
`default_nettype none

module lzss_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               accept,
  input  lzss_pkg::in_item_t in_data,
  input  wire [31:0]        output_length,
  output logic              push,
  output lzss_pkg::cmd_t    cmd
);
  import lzss_pkg::*;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_LOW,
    PH_HIGH
  } phase_t;

  phase_t      phase, phase_next, eff_phase;
  logic [8:0]  flag_shift, flag_shift_next, eff_flag, shifted;
  logic [7:0]  offset_low, offset_low_next;
  logic [31:0] produced, produced_next, eff_prod, remaining;
  logic        finished, finished_next, eff_fin;
  logic [CNT_W-1:0] match_len, emit_cnt;
  logic        lit_done, match_done;

  function automatic phase_t choose(input logic [8:0] fs);
    phase_t ph;
    if (fs <= 9'd1) ph = PH_FLAG;
    else if (fs[0]) ph = PH_LIT;
    else            ph = PH_LOW;
    return ph;
  endfunction

  always_comb begin
    eff_phase = in_data.stream_start ? PH_FLAG : phase;
    eff_flag  = in_data.stream_start ? 9'd0 : flag_shift;
    eff_prod  = in_data.stream_start ? 32'd0 : produced;
    eff_fin   = in_data.stream_start ? 1'b0 : finished;
    shifted   = eff_flag >> 1;

    remaining  = output_length - eff_prod;
    match_len  = CNT_W'({1'b0, in_data.in_byte[3:0]}) + CNT_W'(MATCH_MIN);
    lit_done   = (remaining == 32'd1);
    match_done = (remaining <= {{(32-CNT_W){1'b0}}, match_len});
    emit_cnt   = match_done ? remaining[CNT_W-1:0] : match_len;

    phase_next      = eff_phase;
    flag_shift_next = eff_flag;
    offset_low_next = in_data.stream_start ? 8'd0 : offset_low;
    produced_next   = eff_prod;
    finished_next   = eff_fin;

    push      = accept && in_data.stream_start;
    cmd.clear = in_data.stream_start;
    cmd.kind  = CMD_NOP;
    cmd.data  = {in_data.in_byte[7:4], offset_low};
    cmd.count = emit_cnt;
    cmd.done  = 1'b0;

    if (eff_fin) begin
      // drop input until the next stream starts
    end else if (eff_prod == output_length) begin
      finished_next = 1'b1;
    end else begin
      unique case (eff_phase)
        PH_FLAG: begin
          flag_shift_next = {1'b1, in_data.in_byte};
          phase_next      = choose({1'b1, in_data.in_byte});
        end
        PH_LIT: begin
          push          = accept;
          cmd.kind      = CMD_LIT;
          cmd.data      = {{(WIN_AW-8){1'b0}}, in_data.in_byte};
          cmd.done      = lit_done;
          produced_next = eff_prod + 32'd1;
          if (lit_done) begin
            finished_next = 1'b1;
          end else begin
            flag_shift_next = shifted;
            phase_next      = choose(shifted);
          end
        end
        PH_LOW: begin
          offset_low_next = in_data.in_byte;
          phase_next      = PH_HIGH;
        end
        PH_HIGH: begin
          push          = accept;
          cmd.kind      = CMD_MATCH;
          cmd.done      = match_done;
          produced_next = eff_prod + {{(32-CNT_W){1'b0}}, emit_cnt};
          if (match_done) begin
            finished_next = 1'b1;
          end else begin
            flag_shift_next = shifted;
            phase_next      = choose(shifted);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_shift <= 9'd0;
      offset_low <= 8'd0;
      produced   <= 32'd0;
      finished   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      flag_shift <= flag_shift_next;
      offset_low <= offset_low_next;
      produced   <= produced_next;
      finished   <= finished_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lzss_cmd_fifo.sv -----
// Short command queue between the token parser and the copy engine.
`default_nettype none

module lzss_cmd_fifo (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  lzss_pkg::cmd_t wdata,
  input  wire            pop,
  output lzss_pkg::cmd_t rdata,
  output logic           valid,
  output logic           full
);
  import lzss_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign rdata = entries[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lzss_back.sv -----
// Copy engine: history window, match copy loop and output register.
`default_nettype none

module lzss_back (
  input  wire                 clk,
  input  wire                 rst,
  input  lzss_pkg::cmd_t      cmd,
  input  wire                 cmd_valid,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output lzss_pkg::out_item_t out_data
);
  import lzss_pkg::*;

  logic [7:0]        window [WINDOW_SIZE];
  logic [7:0]        rdata, fwd_byte, emit_byte;
  logic [WIN_AW-1:0] wp, cur_addr, win_off;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  rem_cnt;
  logic              cmd_done, pend, pend_last, pend_done, fwd_hit, rd_valid;
  logic              emit, can_adv, active, issue, wr, addr_valid;

  always_comb begin
    emit       = pend && (!out_valid || out_ready);
    can_adv    = !pend || emit;
    active     = (rem_cnt != '0);
    issue      = active && can_adv;
    cmd_pop    = !active && can_adv && cmd_valid;
    emit_byte  = fwd_hit ? fwd_byte : (rd_valid ? rdata : 8'd0);
    wr         = emit && !pend_done;
    // entries are filled in order from the start pointer, so the fill count
    // tells which ones hold stream data
    win_off    = cur_addr - WRITE_START;
    addr_valid = ({1'b0, win_off} < fill);
  end

  always_ff @(posedge clk) begin
    if (wr)    window[wp] <= emit_byte;
    if (issue) rdata      <= window[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
      rem_cnt   <= '0;
      wp        <= WRITE_START;
      fill      <= '0;
    end else begin
      if (emit) begin
        out_valid            <= 1'b1;
        out_data.out_byte    <= emit_byte;
        out_data.run_last    <= pend_last;
        out_data.stream_done <= pend_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (wr) begin
        wp <= wp + 1'b1;
        if (fill != FILL_FULL) fill <= fill + 1'b1;
      end

      if (emit) pend <= 1'b0;

      if (issue) begin
        pend      <= 1'b1;
        rd_valid  <= addr_valid;
        // the byte written this cycle is not yet visible to the read
        fwd_hit   <= wr && (cur_addr == wp);
        fwd_byte  <= emit_byte;
        pend_last <= (rem_cnt == CNT_W'(1));
        pend_done <= (rem_cnt == CNT_W'(1)) && cmd_done;
        cur_addr  <= cur_addr + 1'b1;
        rem_cnt   <= rem_cnt - 1'b1;
      end

      if (cmd_pop) begin
        if (cmd.clear) begin
          wp   <= WRITE_START;
          fill <= '0;
        end
        unique case (cmd.kind)
          CMD_LIT: begin
            pend      <= 1'b1;
            fwd_hit   <= 1'b1;
            fwd_byte  <= cmd.data[7:0];
            pend_last <= 1'b1;
            pend_done <= cmd.done;
          end
          CMD_MATCH: begin
            cur_addr <= cmd.data;
            rem_cnt  <= cmd.count;
            cmd_done <= cmd.done;
          end
          CMD_NOP: ;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
